### sv/mbl_pkg.sv
// Shared types and constants for the mesh blob loader.
// No dependencies; imported by mesh_blob_loader_top.
`default_nettype none

package mbl_pkg;

   // Default table depths
   localparam int DEF_MAX_VERTICES  = 256;
   localparam int DEF_MAX_FACES     = 256;
   localparam int DEF_MAX_SEGMENTS  = 256;
   localparam int DEF_MAX_PARTICLES = 256;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   // Register indexes on the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OFFSET_X = 3'd0,
      CSR_OFFSET_Y = 3'd1,
      CSR_OFFSET_Z = 3'd2,
      CSR_SCALE_X  = 3'd3,
      CSR_SCALE_Y  = 3'd4,
      CSR_SCALE_Z  = 3'd5,
      CSR_SWAP_XY  = 3'd6
   } csr_index_type;

   // Blob parsing sections
   typedef enum logic [2:0] {
      SEC_HEADER = 3'd0,
      SEC_VERT   = 3'd1,
      SEC_FACE   = 3'd2,
      SEC_SEG    = 3'd3,
      SEC_PART   = 3'd4
   } section_type;

   // Record kinds on the result channel
   typedef enum logic [2:0] {
      KIND_VERTEX   = 3'd0,
      KIND_FACE     = 3'd1,
      KIND_SEGMENT  = 3'd2,
      KIND_PARTICLE = 3'd3,
      KIND_EMPTY    = 3'd4
   } kind_type;

   // One result word
   typedef struct packed {
      kind_type           kind;
      logic [7:0]         slot;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic signed [15:0] coord_z;
      logic [7:0]         point_a;
      logic [7:0]         point_b;
      logic [7:0]         point_c;
      logic signed [7:0]  glyph;
      logic               object_done;
      logic               overflow;
   } rsp_type;

endpackage

`default_nettype wire

### sv/mesh_blob_loader_top.sv
// Mesh blob loader: parses a byte stream of object blobs into table records.
// Depends on mbl_pkg (types, section and kind codes, register indexes).
//
// Usage:
//  - req_ channel: one signed blob byte per word, taken when req_valid is high
//    and req_stall is low. Four header bytes (vertex, face, segment, particle
//    counts) are followed by the records of each non-empty section.
//  - rsp_ channel: one record word on the final byte of each record, or an
//    empty-object word on the last header byte when all counts are zero.
//  - csr_ channel: register writes, always ready; write only while idle.
// Throughput: one byte per cycle while req_stall is low. The byte that
// completes a result is worked in one pass from the held record bytes through
// a small multiply-add or index rebase to the output register, or to the skid
// register while the output register holds a word that is not yet taken.
// Stall: the output register is backed by a one-word skid register, so bytes
// keep flowing while a result waits; req_stall rises only when both hold a
// word, and drops once the receiver takes one.
// Reset: clears the parser to the header, all table counters to zero, the
// offsets and swap to zero and the scales to one. No clearing pass is needed.
`default_nettype none

module mesh_blob_loader_top #(
   parameter int MAX_VERTICES  = mbl_pkg::DEF_MAX_VERTICES,
   parameter int MAX_FACES     = mbl_pkg::DEF_MAX_FACES,
   parameter int MAX_SEGMENTS  = mbl_pkg::DEF_MAX_SEGMENTS,
   parameter int MAX_PARTICLES = mbl_pkg::DEF_MAX_PARTICLES
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // byte input
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic signed [7:0]                req_blob_byte,
   // record output
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [2:0]                            rsp_kind,
   output logic [7:0]                            rsp_slot,
   output logic signed [15:0]                    rsp_coord_x,
   output logic signed [15:0]                    rsp_coord_y,
   output logic signed [15:0]                    rsp_coord_z,
   output logic [7:0]                            rsp_point_a,
   output logic [7:0]                            rsp_point_b,
   output logic [7:0]                            rsp_point_c,
   output logic signed [7:0]                     rsp_glyph,
   output logic                                  rsp_object_done,
   output logic                                  rsp_overflow,
   // register writes
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [mbl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [mbl_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import mbl_pkg::*;

   localparam int VCW = $clog2(MAX_VERTICES);
   localparam int FCW = $clog2(MAX_FACES);
   localparam int SCW = $clog2(MAX_SEGMENTS);
   localparam int PCW = $clog2(MAX_PARTICLES);

   // Rebase: bias by a multiple of the depth so the sum is non-negative,
   // then reduce by a short chain of conditional subtracts.
   localparam int RB_K     = (256 + MAX_VERTICES - 1) / MAX_VERTICES;
   localparam int RB_STEPS = $clog2(RB_K + 2) + 1;
   localparam int RBW      = $clog2((RB_K + 2) * MAX_VERTICES) + 1;

   // Configuration registers
   logic signed [7:0] off_x_ff, off_y_ff, off_z_ff;
   logic [7:0]        scl_x_ff, scl_y_ff, scl_z_ff;
   logic              swap_ff;

   // Parser state
   section_type       section_ff, section_in;
   logic [1:0]        pos_ff, pos_in;
   logic [6:0]        left_ff, left_in;
   logic [6:0]        hc_ff [4];
   logic [6:0]        hc_in [4];
   logic signed [7:0] held_ff [3];
   logic signed [7:0] held_in [3];
   logic [VCW-1:0]    vert_cnt_ff, vert_cnt_in;
   logic [FCW-1:0]    face_cnt_ff, face_cnt_in;
   logic [SCW-1:0]    seg_cnt_ff, seg_cnt_in;
   logic [PCW-1:0]    part_cnt_ff, part_cnt_in;

   // Output register and skid
   rsp_type           out_ff, skid_ff, res_in;
   logic              out_vld_ff, skid_vld_ff, res_vld_in;

   logic              accept;
   logic              out_take;
   logic signed [7:0] b;
   logic [6:0]        cnt_b;
   logic [7:0]        rb_a, rb_b, rb_c;
   logic [15:0]       cx, cy, cz;

   function automatic logic [7:0] rebase(input logic signed [7:0] idx,
                                         input logic [VCW-1:0] vc,
                                         input logic [6:0] nvert);
      logic [RBW-1:0] w;
      w = RBW'(vc) + RBW'(RB_K * MAX_VERTICES) + RBW'(idx) - RBW'(nvert);
      for (int j = RB_STEPS - 1; j >= 0; j--) begin
         if (w >= (RBW'(MAX_VERTICES) << j)) begin
            w = w - (RBW'(MAX_VERTICES) << j);
         end
      end
      return w[7:0];
   endfunction

   function automatic logic [15:0] coord(input logic signed [7:0] off,
                                         input logic [7:0] scl,
                                         input logic signed [7:0] mb);
      logic signed [17:0] s_ext;
      logic signed [17:0] b_ext;
      logic signed [17:0] r;
      s_ext = 18'(signed'({1'b0, scl}));
      b_ext = 18'(mb);
      r = s_ext * b_ext + 18'(off);
      return r[15:0];
   endfunction

   assign accept    = req_valid && !skid_vld_ff;
   assign out_take  = out_vld_ff && !rsp_stall;
   assign req_stall = skid_vld_ff;
   assign csr_ready = 1'b1;

   assign b     = req_blob_byte;
   assign cnt_b = b[7] ? 7'd0 : b[6:0];

   // Rebased indices and transformed coordinates from the held bytes
   assign rb_a = rebase(held_ff[0], vert_cnt_ff, hc_ff[0]);
   assign rb_b = rebase(held_ff[1], vert_cnt_ff, hc_ff[0]);
   assign rb_c = rebase(held_ff[2], vert_cnt_ff, hc_ff[0]);
   assign cx   = swap_ff ? coord(off_x_ff, scl_x_ff, held_ff[1])
                         : coord(off_x_ff, scl_x_ff, held_ff[0]);
   assign cy   = swap_ff ? coord(off_y_ff, scl_y_ff, held_ff[0])
                         : coord(off_y_ff, scl_y_ff, held_ff[1]);
   assign cz   = coord(off_z_ff, scl_z_ff, held_ff[2]);

   // Parse one byte: update state, build a result word
   always_comb begin
      logic [6:0]  cv [4];
      logic [2:0]  cur;
      logic [2:0]  nxt;
      logic [1:0]  last;
      logic        wrapped;

      section_in  = section_ff;
      pos_in      = pos_ff;
      left_in     = left_ff;
      hc_in       = hc_ff;
      held_in     = held_ff;
      vert_cnt_in = vert_cnt_ff;
      face_cnt_in = face_cnt_ff;
      seg_cnt_in  = seg_cnt_ff;
      part_cnt_in = part_cnt_ff;
      res_vld_in  = 1'b0;
      res_in      = '0;
      cv          = hc_ff;
      cur         = section_ff;
      nxt         = SEC_HEADER;
      last        = (section_ff == SEC_PART) ? 2'd1 : 2'd3;
      wrapped     = 1'b0;

      if (accept) begin
         if (section_ff == SEC_HEADER) begin
            hc_in[pos_ff] = cnt_b;
            cv[pos_ff]    = cnt_b;
            if (pos_ff != 2'd3) begin
               pos_in = pos_ff + 2'd1;
            end else begin
               pos_in = 2'd0;
               // first non-empty section
               for (int n = 4; n >= 1; n--) begin
                  if (cv[n-1] != 7'd0) nxt = 3'(n);
               end
               section_in = section_type'(nxt);
               left_in    = (nxt == SEC_HEADER) ? 7'd0 : cv[2'(nxt - 3'd1)];
               if (nxt == SEC_HEADER) begin
                  res_vld_in         = 1'b1;
                  res_in.kind        = KIND_EMPTY;
                  res_in.object_done = 1'b1;
               end
            end
         end else if (pos_ff != last) begin
            // hold a non-final record byte
            held_in[pos_ff] = b;
            pos_in          = pos_ff + 2'd1;
         end else begin
            res_vld_in = 1'b1;
            unique case (section_ff)
               SEC_VERT: begin
                  res_in.kind    = KIND_VERTEX;
                  res_in.slot    = 8'(vert_cnt_ff);
                  res_in.coord_x = cx;
                  res_in.coord_y = cy;
                  res_in.coord_z = cz;
                  wrapped        = (vert_cnt_ff == VCW'(MAX_VERTICES - 1));
                  vert_cnt_in    = wrapped ? '0 : vert_cnt_ff + VCW'(1);
               end
               SEC_FACE: begin
                  res_in.kind    = KIND_FACE;
                  res_in.slot    = 8'(face_cnt_ff);
                  res_in.point_a = rb_a;
                  res_in.point_b = rb_b;
                  res_in.point_c = rb_c;
                  res_in.glyph   = b;
                  wrapped        = (face_cnt_ff == FCW'(MAX_FACES - 1));
                  face_cnt_in    = wrapped ? '0 : face_cnt_ff + FCW'(1);
               end
               SEC_SEG: begin
                  res_in.kind    = KIND_SEGMENT;
                  res_in.slot    = 8'(seg_cnt_ff);
                  res_in.point_a = rb_a;
                  res_in.point_b = rb_b;
                  res_in.glyph   = held_ff[2];
                  wrapped        = (seg_cnt_ff == SCW'(MAX_SEGMENTS - 1));
                  seg_cnt_in     = wrapped ? '0 : seg_cnt_ff + SCW'(1);
               end
               default: begin
                  res_in.kind    = KIND_PARTICLE;
                  res_in.slot    = 8'(part_cnt_ff);
                  res_in.point_a = rb_a;
                  res_in.glyph   = b;
                  wrapped        = (part_cnt_ff == PCW'(MAX_PARTICLES - 1));
                  part_cnt_in    = wrapped ? '0 : part_cnt_ff + PCW'(1);
               end
            endcase
            res_in.overflow = wrapped;
            pos_in          = 2'd0;
            left_in         = (left_ff != 7'd0) ? left_ff - 7'd1 : 7'd0;
            // section finished: advance to the next non-empty one
            if (left_ff <= 7'd1) begin
               for (int n = 4; n >= 1; n--) begin
                  if (3'(n) > cur && cv[n-1] != 7'd0) nxt = 3'(n);
               end
               section_in = section_type'(nxt);
               left_in    = (nxt == SEC_HEADER) ? 7'd0 : cv[2'(nxt - 3'd1)];
               res_in.object_done = (nxt == SEC_HEADER);
            end
         end
      end
   end

   // Hold parser state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         section_ff  <= SEC_HEADER;
         pos_ff      <= 2'd0;
         left_ff     <= 7'd0;
         hc_ff       <= '{default: 7'd0};
         vert_cnt_ff <= '0;
         face_cnt_ff <= '0;
         seg_cnt_ff  <= '0;
         part_cnt_ff <= '0;
      end else begin
         section_ff  <= section_in;
         pos_ff      <= pos_in;
         left_ff     <= left_in;
         hc_ff       <= hc_in;
         vert_cnt_ff <= vert_cnt_in;
         face_cnt_ff <= face_cnt_in;
         seg_cnt_ff  <= seg_cnt_in;
         part_cnt_ff <= part_cnt_in;
      end
   end

   // Held record bytes carry no reset
   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   // Apply register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         off_x_ff <= 8'sd0;
         off_y_ff <= 8'sd0;
         off_z_ff <= 8'sd0;
         scl_x_ff <= 8'd1;
         scl_y_ff <= 8'd1;
         scl_z_ff <= 8'd1;
         swap_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OFFSET_X: off_x_ff <= signed'(csr_wdata);
            CSR_OFFSET_Y: off_y_ff <= signed'(csr_wdata);
            CSR_OFFSET_Z: off_z_ff <= signed'(csr_wdata);
            CSR_SCALE_X:  scl_x_ff <= csr_wdata;
            CSR_SCALE_Y:  scl_y_ff <= csr_wdata;
            CSR_SCALE_Z:  scl_z_ff <= csr_wdata;
            CSR_SWAP_XY:  swap_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Output register with one-word skid; drain skid first
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (out_take) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end
      end else if (!out_vld_ff || out_take) begin
         out_vld_ff <= res_vld_in;
      end else if (res_vld_in) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (out_take) out_ff <= skid_ff;
      end else if (!out_vld_ff || out_take) begin
         out_ff <= res_in;
      end else begin
         skid_ff <= res_in;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_kind        = out_ff.kind;
   assign rsp_slot        = out_ff.slot;
   assign rsp_coord_x     = out_ff.coord_x;
   assign rsp_coord_y     = out_ff.coord_y;
   assign rsp_coord_z     = out_ff.coord_z;
   assign rsp_point_a     = out_ff.point_a;
   assign rsp_point_b     = out_ff.point_b;
   assign rsp_point_c     = out_ff.point_c;
   assign rsp_glyph       = out_ff.glyph;
   assign rsp_object_done = out_ff.object_done;
   assign rsp_overflow    = out_ff.overflow;

endmodule

`default_nettype wire
